>>> hdl/sbr_pkg.sv
// Shared constants and helpers for the 64-bit scale-by-ratio unit.
// No dependencies; every other file of the block refers to this package.
package sbr_pkg;

  // Default operand width of the datapath
  localparam int WORD_WIDTH_DEF = 64;

  // Round a bit count up to whole bytes for stream payloads
  function automatic int byte_pad(input int bits);
    return ((bits + 7) / 8) * 8;
  endfunction

endpackage

>>> hdl/scale_u64_by_ratio_unit.sv
// Top level: floor(value * numerator / denominator) with saturation on overflow.
// Depends on sbr_pkg, sbr_mul and sbr_div.
//
//  channel   direction  tdata (low bit up)                      tuser
//  s_axis    in         value, numerator, denominator, zero pad  -
//  m_axis    out        quotient, zero pad                       overflow
//
// Each item runs through the serial multiplier, the overflow compare and the serial
// divider in turn; a saturated item skips the divider. One item is in work at a
// time. The result waits in an output register, so a stalled m_axis only holds the
// unit once the next item is finished. Reset clears the sequencer and the output
// register; the serial datapath registers are not reset.
module scale_u64_by_ratio_unit #(
  parameter int WORD_WIDTH = sbr_pkg::WORD_WIDTH_DEF
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  // value, numerator, denominator from the lowest bit up
  input  logic [sbr_pkg::byte_pad(3*WORD_WIDTH)-1:0] s_axis_tdata,
  input  logic                                       s_axis_tvalid,
  output logic                                       s_axis_tready,
  // quotient from the lowest bit up
  output logic [sbr_pkg::byte_pad(WORD_WIDTH)-1:0]   m_axis_tdata,
  // overflow
  output logic                                       m_axis_tuser,
  output logic                                       m_axis_tvalid,
  input  logic                                       m_axis_tready
);

  localparam int OUT_TDATA_W = sbr_pkg::byte_pad(WORD_WIDTH);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_CHK,
    ST_DIV,
    ST_OUT
  } state_e;

  state_e                state_q;
  logic [WORD_WIDTH-1:0] den_q;
  logic                  ovf_q;
  logic                  m_valid_q;
  logic                  m_ovf_q;
  logic [WORD_WIDTH-1:0] m_quot_q;

  logic                  s_accept;
  logic                  out_load;
  logic                  mul_busy, mul_done;
  logic [WORD_WIDTH-1:0] prod_hi, prod_lo;
  logic                  div_start, div_busy, div_done;
  logic [WORD_WIDTH-1:0] div_quot;
  logic                  sat;

  assign s_accept  = s_axis_tvalid && s_axis_tready;
  // Load the result register when it is empty or being emptied this cycle
  assign out_load  = (state_q == ST_OUT) && (!m_valid_q || m_axis_tready);
  // High product word at or above the divisor means the quotient does not fit
  assign sat       = (prod_hi >= den_q);
  assign div_start = (state_q == ST_CHK) && !sat;

  sbr_mul #(
    .WORD_WIDTH(WORD_WIDTH)
  ) u_mul (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (s_accept),
    .mcand_i   (s_axis_tdata[WORD_WIDTH-1:0]),
    .mplier_i  (s_axis_tdata[2*WORD_WIDTH-1:WORD_WIDTH]),
    .busy_o    (mul_busy),
    .done_o    (mul_done),
    .prod_hi_o (prod_hi),
    .prod_lo_o (prod_lo)
  );

  sbr_div #(
    .WORD_WIDTH(WORD_WIDTH)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .top_i   (prod_hi),
    .low_i   (prod_lo),
    .den_i   (den_q),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // Sequence one item through multiply, check and divide; hold the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      den_q     <= '0;
      ovf_q     <= 1'b0;
      m_valid_q <= 1'b0;
      m_ovf_q   <= 1'b0;
      m_quot_q  <= '0;
    end else begin
      // Drop the result once its transaction completes and nothing replaces it
      if (m_valid_q && m_axis_tready && !out_load) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (s_accept) begin
            den_q   <= s_axis_tdata[3*WORD_WIDTH-1:2*WORD_WIDTH];
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          if (mul_done) begin
            state_q <= ST_CHK;
          end
        end
        ST_CHK: begin
          ovf_q   <= sat;
          state_q <= sat ? ST_OUT : ST_DIV;
        end
        ST_DIV: begin
          if (div_done) begin
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_load) begin
            m_valid_q <= 1'b1;
            m_ovf_q   <= ovf_q;
            m_quot_q  <= ovf_q ? '1 : div_quot;
            state_q   <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_ovf_q;
  assign m_axis_tdata  = OUT_TDATA_W'(m_quot_q);

  // Multiplier and divider never run together
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(mul_busy && div_busy))
    else $error("multiplier and divider busy at once");

  // The unit takes an item only with both serial units at rest
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !mul_busy && !div_busy)
    else $error("input taken while an item is in work");

  // A saturated result carries an all-ones quotient
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[WORD_WIDTH-1:0] == '1)
    else $error("overflow flagged without saturated quotient");

  // The divider starts only after the overflow check found the quotient in range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(div_busy) |-> $past(state_q) == ST_CHK && !ovf_q)
    else $error("divider started outside the check step");

endmodule

>>> hdl/sbr_mul.sv
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
// Depends on sbr_pkg for the default operand width.
module sbr_mul #(
  parameter int WORD_WIDTH = sbr_pkg::WORD_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [WORD_WIDTH-1:0] mcand_i,
  input  logic [WORD_WIDTH-1:0] mplier_i,
  output logic                  busy_o,
  output logic                  done_o,
  output logic [WORD_WIDTH-1:0] prod_hi_o,
  output logic [WORD_WIDTH-1:0] prod_lo_o
);

  localparam int CNT_W = $clog2(WORD_WIDTH);

  logic                  busy_q;
  logic [CNT_W-1:0]      cnt_q;
  logic [WORD_WIDTH-1:0] mcand_q;
  logic [WORD_WIDTH-1:0] hi_q, hi_d;
  logic [WORD_WIDTH-1:0] lo_q, lo_d;
  logic [WORD_WIDTH:0]   sum;

  // Add the multiplicand when the current multiplier bit is set, then shift right
  always_comb begin
    sum  = {1'b0, hi_q} + (lo_q[0] ? {1'b0, mcand_q} : '0);
    hi_d = sum[WORD_WIDTH:1];
    lo_d = {sum[0], lo_q[WORD_WIDTH-1:1]};
  end

  // Step counter and busy flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_W'(WORD_WIDTH - 1);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  // Product shift register; the multiplier occupies the low half at start
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mcand_q <= mcand_i;
      hi_q    <= '0;
      lo_q    <= mplier_i;
    end else if (busy_q) begin
      hi_q <= hi_d;
      lo_q <= lo_d;
    end
  end

  assign busy_o    = busy_q;
  assign done_o    = busy_q && (cnt_q == '0);
  assign prod_hi_o = hi_q;
  assign prod_lo_o = lo_q;

endmodule

>>> hdl/sbr_div.sv
// Bit-serial restoring divider of a double-width dividend, one quotient bit per cycle.
// Depends on sbr_pkg for the default operand width.
module sbr_div #(
  parameter int WORD_WIDTH = sbr_pkg::WORD_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [WORD_WIDTH-1:0] top_i,
  input  logic [WORD_WIDTH-1:0] low_i,
  input  logic [WORD_WIDTH-1:0] den_i,
  output logic                  busy_o,
  output logic                  done_o,
  output logic [WORD_WIDTH-1:0] quot_o
);

  localparam int CNT_W = $clog2(WORD_WIDTH);

  logic                  busy_q;
  logic [CNT_W-1:0]      cnt_q;
  logic [WORD_WIDTH-1:0] den_q;
  logic [WORD_WIDTH-1:0] rem_q, rem_d;
  logic [WORD_WIDTH-1:0] lo_q, lo_d;
  logic [WORD_WIDTH:0]   shifted;
  logic [WORD_WIDTH+1:0] diff;
  logic                  ge;

  // Shift the next dividend bit into the remainder, trial-subtract the divisor
  always_comb begin
    shifted = {rem_q, lo_q[WORD_WIDTH-1]};
    diff    = {1'b0, shifted} - {2'b00, den_q};
    ge      = !diff[WORD_WIDTH+1];
    rem_d   = ge ? diff[WORD_WIDTH-1:0] : shifted[WORD_WIDTH-1:0];
    lo_d    = {lo_q[WORD_WIDTH-2:0], ge};
  end

  // Step counter and busy flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_W'(WORD_WIDTH - 1);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  // Remainder and dividend/quotient shift registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q <= den_i;
      rem_q <= top_i;
      lo_q  <= low_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      lo_q  <= lo_d;
    end
  end

  assign busy_o = busy_q;
  assign done_o = busy_q && (cnt_q == '0);
  assign quot_o = lo_q;

endmodule
